// ===== hw/rtl/fix_layer_tile_row_renderer_defines.svh =====
// assertion macros shared by the fix layer tile row renderer
`ifndef FIX_LAYER_TILE_ROW_RENDERER_DEFINES_SVH
`define FIX_LAYER_TILE_ROW_RENDERER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define FLTR_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fltr check failed");

// next-cycle implication, checked on clk, off during reset
`define FLTR_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fltr check failed");

`endif

// ===== hw/rtl/fltr_pkg.sv =====
// shared constants, opcodes and queue entry type for the tile row renderer
package fltr_pkg;

    localparam int MAP_COLS    = 40;
    localparam int MAP_ROWS    = 28;
    localparam int TILE_COUNT  = 4096;
    localparam int TILE_AW     = $clog2(TILE_COUNT);
    localparam int PAL_DEPTH   = 256;
    localparam int PIX_PER_ROW = 8;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] OP_PAL_WR = 2'd0;
    localparam logic [1:0] OP_USE_WR = 2'd1;
    localparam logic [1:0] OP_DRAW   = 2'd2;

    typedef struct packed {
        logic        is_pal;
        logic [7:0]  pal_index;
        logic [15:0] pal_value;
        logic [3:0]  bank;
        logic [31:0] pattern;
        logic [5:0]  col;
        logic [7:0]  y;
        logic [7:0]  mask;
    } fltr_op_t;

endpackage

// ===== hw/rtl/fix_layer_tile_row_renderer.sv =====
// top level of the fix layer tile row renderer
//
//  channel   handshake             beat contents
//  input     in_valid / in_stall   opcode, palette write, usage write or draw fields
//  output    out_valid / out_stall pixel_x, pixel_y, pixel_colour, last_pixel
//
// a draw with n visible pixels gives n pixel beats, one per cycle while out_stall is low
// palette writes pass through the back end with no pixel beat; usage writes and dropped draws never reach the queue
// input beats are taken every cycle while the four-entry queue has room and no clearing sweep runs
// a draw beat reaches the output through stage one, the queue and the output register
// after reset in_stall stays high while all 4096 usage map entries are swept clear
`include "fix_layer_tile_row_renderer_defines.svh"

module fix_layer_tile_row_renderer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  pal_index,
    input  logic [15:0] pal_value,
    input  logic        usage_bit,
    input  logic [15:0] map_entry,
    input  logic [31:0] pattern_row,
    input  logic [5:0]  tile_col,
    input  logic [4:0]  tile_row,
    input  logic [2:0]  line_in_tile,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [15:0] pixel_colour,
    output logic        last_pixel
);

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    fltr_pkg::fltr_op_t push_op;
    fltr_pkg::fltr_op_t head_op;

    fltr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .pal_index    (pal_index),
        .pal_value    (pal_value),
        .usage_bit    (usage_bit),
        .map_entry    (map_entry),
        .pattern_row  (pattern_row),
        .tile_col     (tile_col),
        .tile_row     (tile_row),
        .line_in_tile (line_in_tile),
        .q_full       (q_full),
        .push         (push),
        .push_op      (push_op)
    );

    fltr_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .head_op (head_op)
    );

    fltr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_op      (head_op),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .last_pixel   (last_pixel)
    );

    `FLTR_ASSERT_NOW(a_no_push_when_full, push, !q_full)
    `FLTR_ASSERT_NOW(a_no_pop_when_empty, pop, !q_empty)
    `FLTR_ASSERT_NEXT(a_row_continues, out_valid && !out_stall && !last_pixel, out_valid)

endmodule

// ===== hw/rtl/fltr_front.sv =====
// front end: takes input beats, owns the tile usage map, classifies and queues work
module fltr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [7:0]        pal_index,
    input  logic [15:0]       pal_value,
    input  logic              usage_bit,
    input  logic [15:0]       map_entry,
    input  logic [31:0]       pattern_row,
    input  logic [5:0]        tile_col,
    input  logic [4:0]        tile_row,
    input  logic [2:0]        line_in_tile,
    input  logic              q_full,
    output logic              push,
    output fltr_pkg::fltr_op_t push_op
);

    logic                         used_mem [fltr_pkg::TILE_COUNT];
    logic                         used_rd_reg;
    logic                         clr_active_reg;
    logic [fltr_pkg::TILE_AW-1:0] clr_addr_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         s1_keep_reg;
    logic                         s1_keep_next;
    fltr_pkg::fltr_op_t           s1_op_reg;
    fltr_pkg::fltr_op_t           s1_op_next;

    logic [11:0] code;
    logic        code_ok;
    logic        on_map;
    logic        s1_want;
    logic        advance;
    logic        accept;
    logic        mem_we;
    logic        mem_wd;
    logic [fltr_pkg::TILE_AW-1:0] mem_wa;

    assign code    = map_entry[11:0];
    assign code_ok = 13'(code) < 13'(fltr_pkg::TILE_COUNT);
    assign on_map  = (7'(tile_col) < 7'(fltr_pkg::MAP_COLS))
                  && (6'(tile_row) < 6'(fltr_pkg::MAP_ROWS));

    // dropped draws leave stage one without touching the queue
    assign s1_want  = s1_valid_reg && s1_keep_reg && (s1_op_reg.is_pal || used_rd_reg);
    assign push     = s1_want && !q_full;
    assign push_op  = s1_op_reg;
    assign advance  = !s1_want || !q_full;
    assign in_stall = clr_active_reg || !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_op_next.is_pal    = (opcode == fltr_pkg::OP_PAL_WR);
        s1_op_next.pal_index = pal_index;
        s1_op_next.pal_value = pal_value;
        s1_op_next.bank      = map_entry[15:12];
        s1_op_next.pattern   = pattern_row;
        s1_op_next.col       = tile_col;
        s1_op_next.y         = {tile_row, line_in_tile};
        for (int k = 0; k < fltr_pkg::PIX_PER_ROW; k++)
        begin
            s1_op_next.mask[k] = (pattern_row[4*k +: 4] != 4'd0);
        end
        unique case (opcode)
            fltr_pkg::OP_PAL_WR: s1_keep_next = 1'b1;
            fltr_pkg::OP_DRAW:   s1_keep_next = on_map && code_ok
                                             && (s1_op_next.mask != 8'd0);
            default:             s1_keep_next = 1'b0;
        endcase
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // single write port, shared by the clearing sweep and usage writes
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = 1'b0;
        end
        else
        begin
            mem_we = accept && (opcode == fltr_pkg::OP_USE_WR) && code_ok;
            mem_wa = code[fltr_pkg::TILE_AW-1:0];
            mem_wd = usage_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_mem[mem_wa] <= mem_wd;
        end
        if (accept)
        begin
            used_rd_reg <= used_mem[code[fltr_pkg::TILE_AW-1:0]];
            s1_op_reg   <= s1_op_next;
            s1_keep_reg <= s1_keep_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == fltr_pkg::TILE_AW'(fltr_pkg::TILE_COUNT - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/fltr_queue.sv =====
// short fifo of classified work between front and back end
module fltr_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fltr_pkg::fltr_op_t push_op,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output fltr_pkg::fltr_op_t head_op
);

    fltr_pkg::fltr_op_t        mem_reg [fltr_pkg::Q_DEPTH];
    logic [fltr_pkg::Q_AW-1:0] wr_ptr_reg;
    logic [fltr_pkg::Q_AW-1:0] rd_ptr_reg;
    logic [fltr_pkg::Q_CW-1:0] count_reg;
    logic [fltr_pkg::Q_CW-1:0] count_next;

    assign full    = (count_reg == fltr_pkg::Q_CW'(fltr_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/fltr_back.sv =====
// back end: owns the palette, walks visible pixels and drives the output register
module fltr_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  fltr_pkg::fltr_op_t head_op,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [8:0]         pixel_x,
    output logic [7:0]         pixel_y,
    output logic [15:0]        pixel_colour,
    output logic               last_pixel
);

    logic [15:0]                  pal_mem [fltr_pkg::PAL_DEPTH];
    logic [fltr_pkg::PAL_DEPTH-1:0] pal_vld_reg;
    logic                         started_reg;
    logic [7:0]                   rem_mask_reg;
    logic                         out_valid_reg;
    logic [8:0]                   x_reg;
    logic [7:0]                   y_reg;
    logic                         last_reg;
    logic [15:0]                  colour_reg;
    logic                         colour_vld_reg;

    logic       advance;
    logic       pal_we;
    logic       emit;
    logic [7:0] mask_cur;
    logic [7:0] mask_rest;
    logic [2:0] sel_idx;
    logic [3:0] nib;
    logic [7:0] pal_addr;

    assign advance = !out_valid_reg || !out_stall;
    assign pal_we  = advance && !q_empty && head_op.is_pal;
    assign emit    = advance && !q_empty && !head_op.is_pal;

    // the head draw's own mask until its first pixel goes out
    assign mask_cur  = started_reg ? rem_mask_reg : head_op.mask;
    assign mask_rest = mask_cur & (mask_cur - 8'd1);
    assign nib       = head_op.pattern[4*sel_idx +: 4];
    assign pal_addr  = {head_op.bank, nib};
    assign pop       = pal_we || (emit && (mask_rest == 8'd0));

    always_comb
    begin
        sel_idx = '0;
        for (int k = fltr_pkg::PIX_PER_ROW - 1; k >= 0; k--)
        begin
            if (mask_cur[k])
            begin
                sel_idx = 3'(k);
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = x_reg;
    assign pixel_y      = y_reg;
    assign last_pixel   = last_reg;
    assign pixel_colour = colour_vld_reg ? colour_reg : 16'd0;

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[head_op.pal_index] <= head_op.pal_value;
        end
        if (emit)
        begin
            colour_reg <= pal_mem[pal_addr];
            x_reg      <= {head_op.col, sel_idx};
            y_reg      <= head_op.y;
            last_reg   <= (mask_rest == 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_vld_reg    <= '0;
            started_reg    <= 1'b0;
            rem_mask_reg   <= '0;
            out_valid_reg  <= 1'b0;
            colour_vld_reg <= 1'b0;
        end
        else
        begin
            if (pal_we)
            begin
                pal_vld_reg[head_op.pal_index] <= 1'b1;
            end
            if (advance)
            begin
                out_valid_reg <= emit;
            end
            if (emit)
            begin
                colour_vld_reg <= pal_vld_reg[pal_addr];
                rem_mask_reg   <= mask_rest;
                started_reg    <= (mask_rest != 8'd0);
            end
        end
    end

endmodule
